>>> rtl/core/spiseq_pkg.sv
// spiseq_pkg: shared types, constants and the beat script table of the
// spi eeprom command sequencer. no dependencies.
`default_nettype none

package spiseq_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAGE_SIZE   = 32;
    localparam int unsigned CHUNK_W     = $clog2(PAGE_SIZE + 1);
    localparam int unsigned JOBQ_DEPTH  = 4;
    localparam int unsigned JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);
    localparam int unsigned JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);
    localparam int unsigned STEP_W      = 4;
    localparam int unsigned ROM_IDX_W   = 6;
    localparam int unsigned WIP_BIT     = 0;

    // device commands
    localparam logic [BYTE_W-1:0] CMD_WRSR  = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_WRDI  = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_RDSR  = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;

    typedef enum logic [2:0] {
        OPC_WRITE_REQ  = 3'd0,
        OPC_WRITE_BYTE = 3'd1,
        OPC_READ_REQ   = 3'd2,
        OPC_DEV_BYTE   = 3'd3,
        OPC_STATUS_WR  = 3'd4
    } opc_t;

    typedef enum logic [2:0] {
        ACT_SEL_LOW  = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_RECV     = 3'd2,
        ACT_SEL_HIGH = 3'd3,
        ACT_DELIVER  = 3'd4,
        ACT_DONE     = 3'd5,
        ACT_REJECT   = 3'd6
    } action_t;

    // job kinds passed from front to back
    typedef enum logic [3:0] {
        K_DONE,
        K_REJECT,
        K_STATUS,
        K_WRITE_START,
        K_READ_START,
        K_DATA_BYTE,
        K_DATA_LAST,
        K_POLL_BUSY,
        K_POLL_NEXT,
        K_POLL_DONE,
        K_RDATA_MORE,
        K_RDATA_END
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [ADDR_W-1:0]  addr;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jobq_status_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_CMD,
        SRC_DATA,
        SRC_ADDR_HI,
        SRC_ADDR_LO
    } src_t;

    typedef struct packed {
        action_t            action;
        src_t               src;
        logic [BYTE_W-1:0]  cmd;
        logic               last;
    } rom_entry_t;

    // first script line of each job kind; several kinds share tails
    function automatic logic [ROM_IDX_W-1:0] rom_start(input kind_t k);
        logic [ROM_IDX_W-1:0] s;
        unique case (k)
            K_STATUS:      s = 6'd0;
            K_POLL_DONE:   s = 6'd6;
            K_DONE:        s = 6'd10;
            K_POLL_NEXT:   s = 6'd11;
            K_WRITE_START: s = 6'd15;
            K_READ_START:  s = 6'd22;
            K_DATA_LAST:   s = 6'd27;
            K_POLL_BUSY:   s = 6'd31;
            K_DATA_BYTE:   s = 6'd32;
            K_RDATA_MORE:  s = 6'd33;
            K_RDATA_END:   s = 6'd35;
            default:       s = 6'd38;
        endcase
        return s;
    endfunction

    // beat script: one line per bus action
    function automatic rom_entry_t rom_entry(input logic [ROM_IDX_W-1:0] idx);
        rom_entry_t e;
        unique case (idx)
            // status register write, its tail doubles as poll-done and done
            6'd0:  e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd1:  e = '{ACT_SEND,     SRC_CMD,     CMD_WREN,  1'b0};
            6'd2:  e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd3:  e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd4:  e = '{ACT_SEND,     SRC_CMD,     CMD_WRSR,  1'b0};
            6'd5:  e = '{ACT_SEND,     SRC_DATA,    8'h00,     1'b0};
            6'd6:  e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd7:  e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd8:  e = '{ACT_SEND,     SRC_CMD,     CMD_WRDI,  1'b0};
            6'd9:  e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd10: e = '{ACT_DONE,     SRC_ZERO,    8'h00,     1'b1};
            // poll finished, more to write: wrdi then falls into chunk start
            6'd11: e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd12: e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd13: e = '{ACT_SEND,     SRC_CMD,     CMD_WRDI,  1'b0};
            6'd14: e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            // chunk start
            6'd15: e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd16: e = '{ACT_SEND,     SRC_CMD,     CMD_WREN,  1'b0};
            6'd17: e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd18: e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd19: e = '{ACT_SEND,     SRC_CMD,     CMD_WRITE, 1'b0};
            6'd20: e = '{ACT_SEND,     SRC_ADDR_HI, 8'h00,     1'b0};
            6'd21: e = '{ACT_SEND,     SRC_ADDR_LO, 8'h00,     1'b1};
            // read start
            6'd22: e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd23: e = '{ACT_SEND,     SRC_CMD,     CMD_READ,  1'b0};
            6'd24: e = '{ACT_SEND,     SRC_ADDR_HI, 8'h00,     1'b0};
            6'd25: e = '{ACT_SEND,     SRC_ADDR_LO, 8'h00,     1'b0};
            6'd26: e = '{ACT_RECV,     SRC_ZERO,    8'h00,     1'b1};
            // last byte of a chunk, then status poll; its tail is poll-busy
            6'd27: e = '{ACT_SEND,     SRC_DATA,    8'h00,     1'b0};
            6'd28: e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd29: e = '{ACT_SEL_LOW,  SRC_ZERO,    8'h00,     1'b0};
            6'd30: e = '{ACT_SEND,     SRC_CMD,     CMD_RDSR,  1'b0};
            6'd31: e = '{ACT_RECV,     SRC_ZERO,    8'h00,     1'b1};
            // plain data byte
            6'd32: e = '{ACT_SEND,     SRC_DATA,    8'h00,     1'b1};
            // read byte, more to come
            6'd33: e = '{ACT_DELIVER,  SRC_DATA,    8'h00,     1'b0};
            6'd34: e = '{ACT_RECV,     SRC_ZERO,    8'h00,     1'b1};
            // final read byte
            6'd35: e = '{ACT_DELIVER,  SRC_DATA,    8'h00,     1'b0};
            6'd36: e = '{ACT_SEL_HIGH, SRC_ZERO,    8'h00,     1'b0};
            6'd37: e = '{ACT_DONE,     SRC_ZERO,    8'h00,     1'b1};
            default: e = '{ACT_REJECT, SRC_ZERO,    8'h00,     1'b1};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/spiseq_front.sv
// spiseq_front: request state machine that classifies each accepted beat
// into a job for the back end. depends on spiseq_pkg.
`default_nettype none

module spiseq_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [2:0]                 opcode,
    input  logic [spiseq_pkg::ADDR_W-1:0] address,
    input  logic [spiseq_pkg::LEN_W-1:0]  length,
    input  logic [spiseq_pkg::BYTE_W-1:0] data_byte,
    output spiseq_pkg::job_t           job
);
    import spiseq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WDATA = 4'b0010,
        S_WPOLL = 4'b0100,
        S_RDATA = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [LEN_W-1:0]     rem_dec;
    logic [CHUNK_W-1:0]   chunk_dec;
    kind_t                kind;

    // bytes until the page boundary, capped by what is left
    function automatic logic [CHUNK_W-1:0] chunk_size(input logic [ADDR_W-1:0] a,
                                                      input logic [LEN_W-1:0] r);
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] room;
        off  = a % ADDR_W'(PAGE_SIZE);
        room = ADDR_W'(PAGE_SIZE) - off;
        return (r < room) ? CHUNK_W'(r) : CHUNK_W'(room);
    endfunction

    assign rem_dec   = (rem_reg != '0) ? rem_reg - 1'b1 : '0;
    assign chunk_dec = (chunk_reg != '0) ? chunk_reg - 1'b1 : '0;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        kind       = K_REJECT;
        unique case (opcode)
            OPC_WRITE_REQ:
            begin
                if (state_reg == S_IDLE)
                begin
                    if (length == '0)
                    begin
                        kind = K_DONE;
                    end
                    else
                    begin
                        kind       = K_WRITE_START;
                        state_next = S_WDATA;
                        addr_next  = address;
                        rem_next   = length;
                        chunk_next = chunk_size(address, length);
                    end
                end
            end
            OPC_READ_REQ:
            begin
                if (state_reg == S_IDLE)
                begin
                    if (length == '0)
                    begin
                        kind = K_DONE;
                    end
                    else
                    begin
                        kind       = K_READ_START;
                        state_next = S_RDATA;
                        addr_next  = address;
                        rem_next   = length;
                    end
                end
            end
            OPC_STATUS_WR:
            begin
                if (state_reg == S_IDLE)
                begin
                    kind = K_STATUS;
                end
            end
            OPC_WRITE_BYTE:
            begin
                if (state_reg == S_WDATA)
                begin
                    addr_next  = addr_reg + 1'b1;
                    rem_next   = rem_dec;
                    chunk_next = chunk_dec;
                    if (chunk_dec == '0)
                    begin
                        kind       = K_DATA_LAST;
                        state_next = S_WPOLL;
                    end
                    else
                    begin
                        kind = K_DATA_BYTE;
                    end
                end
            end
            OPC_DEV_BYTE:
            begin
                if (state_reg == S_WPOLL)
                begin
                    if (data_byte[WIP_BIT])
                    begin
                        kind = K_POLL_BUSY;
                    end
                    else if (rem_reg != '0)
                    begin
                        kind       = K_POLL_NEXT;
                        state_next = S_WDATA;
                        chunk_next = chunk_size(addr_reg, rem_reg);
                    end
                    else
                    begin
                        kind       = K_POLL_DONE;
                        state_next = S_IDLE;
                    end
                end
                else if (state_reg == S_RDATA)
                begin
                    addr_next = addr_reg + 1'b1;
                    rem_next  = rem_dec;
                    if (rem_dec != '0)
                    begin
                        kind = K_RDATA_MORE;
                    end
                    else
                    begin
                        kind       = K_RDATA_END;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                kind = K_REJECT;
            end
        endcase
    end

    // job addr is the updated address, the start for chunk and read jobs
    assign job = '{kind: kind, data_byte: data_byte, addr: addr_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            addr_reg  <= '0;
            rem_reg   <= '0;
            chunk_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/spiseq_jobq.sv
// spiseq_jobq: small register queue of jobs between front and back.
// depends on spiseq_pkg.
`default_nettype none

module spiseq_jobq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  spiseq_pkg::job_t         push_job,
    input  logic                     pop,
    output spiseq_pkg::job_t         head,
    output spiseq_pkg::jobq_status_t status
);
    import spiseq_pkg::*;

    job_t                  slot_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOBQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOBQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign status.full  = (count_reg == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/spiseq_back.sv
// spiseq_back: walks the beat script of the head job, one bus action per
// cycle into the free or draining result register. depends on spiseq_pkg.
`default_nettype none

module spiseq_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spiseq_pkg::job_t              head,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [2:0]                    action,
    output logic [spiseq_pkg::BYTE_W-1:0] out_byte,
    output logic                          last
);
    import spiseq_pkg::*;

    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 valid_reg, valid_next;
    action_t              action_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic                 last_reg;
    logic [ROM_IDX_W-1:0] idx;
    rom_entry_t           ent;
    logic [BYTE_W-1:0]    beat_byte;
    logic                 advance;

    assign idx = rom_start(head.kind) + ROM_IDX_W'(step_reg);
    assign ent = rom_entry(idx);

    always_comb
    begin
        unique case (ent.src)
            SRC_CMD:     beat_byte = ent.cmd;
            SRC_DATA:    beat_byte = head.data_byte;
            SRC_ADDR_HI: beat_byte = head.addr[ADDR_W-1 -: BYTE_W];
            SRC_ADDR_LO: beat_byte = head.addr[BYTE_W-1:0];
            default:     beat_byte = '0;
        endcase
    end

    // a job is waiting and the result register is free or being drained this cycle
    assign advance = !q_empty && (!valid_reg || pop);
    assign q_pop   = advance && ent.last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            step_next  = ent.last ? '0 : step_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg <= ent.action;
            byte_reg   <= beat_byte;
            last_reg   <= ent.last;
        end
    end

    assign empty    = !valid_reg;
    assign action   = action_reg;
    assign out_byte = byte_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/spi_eeprom_command_sequencer.sv
// spi_eeprom_command_sequencer: top level, joins front, job queue and back.
// depends on spiseq_pkg, spiseq_front, spiseq_jobq, spiseq_back.
//
//   channel   handshake         beat content
//   -------   ---------------   ------------------------------------------
//   request   push / full       opcode, address, length, data_byte
//   result    empty / pop       action, out_byte, last (last beat of item)
//
// a request beat is taken in the cycle it arrives while the job queue
// (four entries) has room; the front classifies it in that same cycle
// each item expands into 1 to 11 result beats, one per cycle from the
// beat script walker while the result register is free or being drained
// reset clears the request state machine, queue pointers and count, script step and result valid
// a stalled result consumer backs up the queue; full rises only when it
// holds four jobs
`default_nettype none

module spi_eeprom_command_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    opcode,
    input  logic [spiseq_pkg::ADDR_W-1:0] address,
    input  logic [spiseq_pkg::LEN_W-1:0]  length,
    input  logic [spiseq_pkg::BYTE_W-1:0] data_byte,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    action,
    output logic [spiseq_pkg::BYTE_W-1:0] out_byte,
    output logic                          last
);
    import spiseq_pkg::*;

    job_t         new_job;
    job_t         head_job;
    jobq_status_t q_status;
    logic         accept;
    logic         q_pop;

    // a request beat moves when the queue can take its job
    assign accept = push && !q_status.full;
    assign full   = q_status.full;

    // front: request state, page chunking, classification
    spiseq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .address   (address),
        .length    (length),
        .data_byte (data_byte),
        .job       (new_job)
    );

    // decouples classification from bus beat generation
    spiseq_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (new_job),
        .pop      (q_pop),
        .head     (head_job),
        .status   (q_status)
    );

    // back: one bus action per cycle into the result register while it is free or drained
    spiseq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_job),
        .q_empty  (q_status.empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .action   (action),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

`default_nettype wire

>>> rtl/core/spiseq_checker.sv
// spiseq_checker: port-level assertions on the sequencer result stream,
// bound to the top level. depends on spiseq_pkg.
`default_nettype none

module spiseq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [2:0]                    action,
    input  logic [spiseq_pkg::BYTE_W-1:0] out_byte,
    input  logic                          last
);
    import spiseq_pkg::*;

    // a waiting beat that is not taken holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(action) && $stable(out_byte) && $stable(last))
        else $error("result beat changed while stalled");

    // only sends and deliveries carry a byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && action != ACT_SEND && action != ACT_DELIVER |-> out_byte == '0)
        else $error("nonzero byte on a non-data action");

    // done and rejected always close an item
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (action == ACT_DONE || action == ACT_REJECT) |-> last)
        else $error("done or reject without last");

    // no item ends on a chip select edge or a delivery
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && last |-> action != ACT_SEL_LOW && action != ACT_SEL_HIGH
                           && action != ACT_DELIVER)
        else $error("last on an action that never ends an item");

endmodule

bind spi_eeprom_command_sequencer spiseq_checker u_checker (.*);

`default_nettype wire
